// File: sv/gb3_pkg.sv
// shared constants and types for the 3x3 gaussian blur
// used by every module of the block; depends on nothing
package gb3_pkg;

    // image geometry limits
    localparam int MAX_WIDTH   = 1024;
    localparam int PIXEL_BITS  = 8;
    localparam int COL_BITS    = $clog2(MAX_WIDTH);
    localparam int ROW_BITS    = 16;
    localparam int WIDTH_BITS  = 11;
    localparam int CFG_BITS    = 16;

    // kernel column sum (1 2 1) and full sum (x16) widths
    localparam int COL_SUM_BITS = PIXEL_BITS + 2;
    localparam int SUM_BITS     = PIXEL_BITS + 4;
    localparam int SHIFT_BITS   = 4;

    // output queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1) + 1;

    // configuration register indexes
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    // position tag carried along with a pixel
    typedef struct packed {
        logic                emit;
        logic [ROW_BITS-1:0] row;
        logic [COL_BITS-1:0] col;
        logic                last;
    } pos_t;

    // one finished result word
    typedef struct packed {
        logic [PIXEL_BITS-1:0] value;
        logic [ROW_BITS-1:0]   row;
        logic [COL_BITS-1:0]   col;
        logic                  last;
    } res_t;

endpackage

// File: sv/gaussian_blur_3x3.sv
// top level of the 3x3 gaussian blur: configuration, position counters,
// admission control; uses gb3_pkg, gb3_line_buffer, gb3_window, gb3_result_fifo
//
// Pixels arrive in raster order, one word per clock when the output side keeps
// up; the two previous rows sit in two 1024x8 line memories that are read on
// accept and written back the next cycle, with forwarding when the next word
// hits the same column. Results pass the line-buffer and window stages into a
// four-entry output queue; the input stalls only when that queue plus the words
// still in flight could overflow it. A result is given for the window whose
// top-left pixel is (row, column) when the pixel at (row+2, column+2) arrives.
// image_width is clamped to 3..1024 and image_height to at least 3; write them
// only while the block is idle.
module gaussian_blur_3x3
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic                              cfg_index,
    input  logic [gb3_pkg::CFG_BITS-1:0]      cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [gb3_pkg::PIXEL_BITS-1:0]    pixel_value,
    input  logic                              frame_start,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [gb3_pkg::PIXEL_BITS-1:0]    filtered_value,
    output logic [gb3_pkg::ROW_BITS-1:0]      out_row,
    output logic [gb3_pkg::COL_BITS-1:0]      out_column,
    output logic                              last_of_image
);

    localparam logic [gb3_pkg::WIDTH_BITS-1:0] MaxW =
        gb3_pkg::WIDTH_BITS'(gb3_pkg::MAX_WIDTH);
    localparam logic [gb3_pkg::WIDTH_BITS-1:0] MinW = gb3_pkg::WIDTH_BITS'(3);
    localparam logic [gb3_pkg::ROW_BITS-1:0]   MinH = gb3_pkg::ROW_BITS'(3);
    localparam logic [gb3_pkg::FIFO_CNT_BITS-1:0] FifoFull =
        gb3_pkg::FIFO_CNT_BITS'(gb3_pkg::FIFO_DEPTH);

    logic [gb3_pkg::WIDTH_BITS-1:0] width_reg;
    logic [gb3_pkg::ROW_BITS-1:0]   height_reg;
    logic [gb3_pkg::ROW_BITS-1:0]   row_reg;
    logic [gb3_pkg::COL_BITS-1:0]   col_reg;

    logic [gb3_pkg::WIDTH_BITS-1:0] eff_w;
    logic [gb3_pkg::WIDTH_BITS-1:0] eff_w_m1;
    logic [gb3_pkg::ROW_BITS-1:0]   eff_h_m1;
    logic [gb3_pkg::ROW_BITS-1:0]   r_cur;
    logic [gb3_pkg::COL_BITS-1:0]   c_raw;
    logic [gb3_pkg::COL_BITS-1:0]   c_cur;
    logic                           row_end;
    logic                           col_end;
    logic                           accept;
    gb3_pkg::pos_t                  pos_in;
    gb3_pkg::pos_t                  s1_pos_reg;

    logic                           col_valid;
    logic [gb3_pkg::PIXEL_BITS-1:0] col_upper;
    logic [gb3_pkg::PIXEL_BITS-1:0] col_middle;
    logic [gb3_pkg::PIXEL_BITS-1:0] col_lower;
    logic                           res_valid;
    gb3_pkg::res_t                  res;
    gb3_pkg::res_t                  out_word;
    logic [gb3_pkg::FIFO_CNT_BITS-1:0] level;
    logic [gb3_pkg::FIFO_CNT_BITS-1:0] pending;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= MaxW;
            height_reg <= gb3_pkg::ROW_BITS'(1024);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                gb3_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg_data[gb3_pkg::WIDTH_BITS-1:0];
                gb3_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default:                   width_reg  <= width_reg;
            endcase
        end
    end

    // clamped geometry
    always_comb
    begin
        if (width_reg < MinW)
        begin
            eff_w = MinW;
        end
        else if (width_reg > MaxW)
        begin
            eff_w = MaxW;
        end
        else
        begin
            eff_w = width_reg;
        end
        eff_w_m1 = eff_w - 1'b1;
        eff_h_m1 = ((height_reg < MinH) ? MinH : height_reg) - 1'b1;
    end

    // position of the incoming pixel
    always_comb
    begin
        r_cur = frame_start ? '0 : row_reg;
        c_raw = frame_start ? '0 : col_reg;
        if ({1'b0, c_raw} >= eff_w)
        begin
            c_cur = eff_w_m1[gb3_pkg::COL_BITS-1:0];
        end
        else
        begin
            c_cur = c_raw;
        end
        row_end     = (r_cur >= eff_h_m1);
        col_end     = ({1'b0, c_cur} >= eff_w_m1);
        pos_in.emit = (r_cur >= gb3_pkg::ROW_BITS'(2)) && (c_cur >= gb3_pkg::COL_BITS'(2));
        pos_in.row  = r_cur - gb3_pkg::ROW_BITS'(2);
        pos_in.col  = c_cur - gb3_pkg::COL_BITS'(2);
        pos_in.last = row_end && col_end;
    end

    // admission: queue plus in-flight results must leave room for one more
    assign pending  = level
                    + gb3_pkg::FIFO_CNT_BITS'(col_valid && s1_pos_reg.emit)
                    + gb3_pkg::FIFO_CNT_BITS'(res_valid);
    assign in_stall = (pending >= FifoFull);
    assign accept   = in_valid && !in_stall;

    // position counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (accept)
        begin
            if (col_end)
            begin
                col_reg <= '0;
                row_reg <= row_end ? '0 : r_cur + 1'b1;
            end
            else
            begin
                col_reg <= c_cur + 1'b1;
                row_reg <= r_cur;
            end
        end
    end

    // position tag alongside the memory read
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pos_reg <= pos_in;
        end
    end

    gb3_line_buffer u_line_buffer
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd_en      (accept),
        .rd_addr    (c_cur),
        .rd_pix     (pixel_value),
        .col_valid  (col_valid),
        .col_upper  (col_upper),
        .col_middle (col_middle),
        .col_lower  (col_lower)
    );

    gb3_window u_window
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .col_valid  (col_valid),
        .col_upper  (col_upper),
        .col_middle (col_middle),
        .col_lower  (col_lower),
        .col_pos    (s1_pos_reg),
        .res_valid  (res_valid),
        .res        (res)
    );

    gb3_result_fifo u_result_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (res_valid),
        .push_word  (res),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_word   (out_word),
        .level      (level)
    );

    assign filtered_value = out_word.value;
    assign out_row        = out_word.row;
    assign out_column     = out_word.col;
    assign last_of_image  = out_word.last;

endmodule

// File: sv/gb3_line_buffer.sv
// two line memories holding the previous two rows, with read-modify-write
// and same-address forwarding; depends on gb3_pkg
module gb3_line_buffer
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              rd_en,
    input  logic [gb3_pkg::COL_BITS-1:0]      rd_addr,
    input  logic [gb3_pkg::PIXEL_BITS-1:0]    rd_pix,
    output logic                              col_valid,
    output logic [gb3_pkg::PIXEL_BITS-1:0]    col_upper,
    output logic [gb3_pkg::PIXEL_BITS-1:0]    col_middle,
    output logic [gb3_pkg::PIXEL_BITS-1:0]    col_lower
);

    logic [gb3_pkg::PIXEL_BITS-1:0] upper_mem  [gb3_pkg::MAX_WIDTH];
    logic [gb3_pkg::PIXEL_BITS-1:0] middle_mem [gb3_pkg::MAX_WIDTH];

    logic [gb3_pkg::PIXEL_BITS-1:0] upper_rd_reg;
    logic [gb3_pkg::PIXEL_BITS-1:0] middle_rd_reg;
    logic                           s1_valid_reg;
    logic [gb3_pkg::COL_BITS-1:0]   s1_addr_reg;
    logic [gb3_pkg::PIXEL_BITS-1:0] s1_pix_reg;
    logic                           fwd_hit_reg;
    logic [gb3_pkg::PIXEL_BITS-1:0] fwd_upper_reg;
    logic [gb3_pkg::PIXEL_BITS-1:0] fwd_middle_reg;

    logic [gb3_pkg::PIXEL_BITS-1:0] upper_eff;
    logic [gb3_pkg::PIXEL_BITS-1:0] middle_eff;

    // pick forwarded data when the previous word wrote this entry
    assign upper_eff  = fwd_hit_reg ? fwd_upper_reg  : upper_rd_reg;
    assign middle_eff = fwd_hit_reg ? fwd_middle_reg : middle_rd_reg;

    // memory read on accept, written back in the following cycle
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            upper_rd_reg  <= upper_mem[rd_addr];
            middle_rd_reg <= middle_mem[rd_addr];
        end
        if (s1_valid_reg)
        begin
            upper_mem[s1_addr_reg]  <= middle_eff;
            middle_mem[s1_addr_reg] <= s1_pix_reg;
        end
    end

    // stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= rd_en;
            if (rd_en)
            begin
                fwd_hit_reg <= s1_valid_reg && (s1_addr_reg == rd_addr);
            end
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            s1_addr_reg    <= rd_addr;
            s1_pix_reg     <= rd_pix;
            fwd_upper_reg  <= middle_eff;
            fwd_middle_reg <= s1_pix_reg;
        end
    end

    assign col_valid  = s1_valid_reg;
    assign col_upper  = upper_eff;
    assign col_middle = middle_eff;
    assign col_lower  = s1_pix_reg;

endmodule

// File: sv/gb3_window.sv
// 3x3 window kept as three weighted column sums, and the final kernel sum
// depends on gb3_pkg
module gb3_window
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              col_valid,
    input  logic [gb3_pkg::PIXEL_BITS-1:0]    col_upper,
    input  logic [gb3_pkg::PIXEL_BITS-1:0]    col_middle,
    input  logic [gb3_pkg::PIXEL_BITS-1:0]    col_lower,
    input  gb3_pkg::pos_t                     col_pos,
    output logic                              res_valid,
    output gb3_pkg::res_t                     res
);

    logic [gb3_pkg::COL_SUM_BITS-1:0] col_sum;
    logic [gb3_pkg::COL_SUM_BITS-1:0] left_reg;
    logic [gb3_pkg::COL_SUM_BITS-1:0] center_reg;
    logic [gb3_pkg::COL_SUM_BITS-1:0] right_reg;
    logic                             s2_valid_reg;
    gb3_pkg::pos_t                    s2_pos_reg;
    logic [gb3_pkg::SUM_BITS-1:0]     total;

    // vertical 1 2 1 weighting of the incoming column
    assign col_sum = gb3_pkg::COL_SUM_BITS'(col_upper)
                   + gb3_pkg::COL_SUM_BITS'({col_middle, 1'b0})
                   + gb3_pkg::COL_SUM_BITS'(col_lower);

    // column shift and result stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg     <= '0;
            center_reg   <= '0;
            right_reg    <= '0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (col_valid)
            begin
                left_reg   <= center_reg;
                center_reg <= right_reg;
                right_reg  <= col_sum;
            end
            s2_valid_reg <= col_valid && col_pos.emit;
        end
    end

    // position tag follows the pixel
    always_ff @(posedge clk)
    begin
        if (col_valid)
        begin
            s2_pos_reg <= col_pos;
        end
    end

    // horizontal 1 2 1 weighting, divide by 16
    assign total = gb3_pkg::SUM_BITS'(left_reg)
                 + gb3_pkg::SUM_BITS'({center_reg, 1'b0})
                 + gb3_pkg::SUM_BITS'(right_reg);

    assign res_valid = s2_valid_reg;
    assign res.value = total[gb3_pkg::SUM_BITS-1:gb3_pkg::SHIFT_BITS];
    assign res.row   = s2_pos_reg.row;
    assign res.col   = s2_pos_reg.col;
    assign res.last  = s2_pos_reg.last;

endmodule

// File: sv/gb3_result_fifo.sv
// small output queue that decouples the pipeline from the result stall
// depends on gb3_pkg
module gb3_result_fifo
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    input  gb3_pkg::res_t                       push_word,
    output logic                                out_valid,
    input  logic                                out_stall,
    output gb3_pkg::res_t                       out_word,
    output logic [gb3_pkg::FIFO_CNT_BITS-1:0]   level
);

    gb3_pkg::res_t                          entry_reg [gb3_pkg::FIFO_DEPTH];
    logic [gb3_pkg::FIFO_PTR_BITS-1:0]      wr_ptr_reg;
    logic [gb3_pkg::FIFO_PTR_BITS-1:0]      rd_ptr_reg;
    logic [gb3_pkg::FIFO_CNT_BITS-1:0]      count_reg;
    logic [gb3_pkg::FIFO_CNT_BITS-1:0]      count_next;
    logic                                   pop;

    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && !out_stall;
    assign out_word  = entry_reg[rd_ptr_reg];
    assign level     = count_reg;

    // occupancy update
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule
